FILE: rtl/tlsr_pkg.sv
// Shared types and constants of the thick line span rasterizer.
package tlsr_pkg;

	localparam int RAD_W      = 6;
	localparam int COLOR_W    = 16;
	localparam int LEN_W      = 8;
	localparam int IDX_W      = 7;
	localparam int BND_W      = 12;
	localparam int SQ_W       = 15;
	localparam int FIFO_DEPTH = 4;

	// limit = r*707/1000 + 1, taken as (r * LIM_MUL) >> LIM_SHIFT plus one.
	localparam int LIM_SHIFT = 26;
	localparam logic [LIM_SHIFT-1:0] LIM_MUL = 26'd47445967;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd3;

	typedef enum logic [5:0] {
		PH_ROW0 = 6'b000001,
		PH_SCAN = 6'b000010,
		PH_TOPW = 6'b000100,
		PH_BOTW = 6'b001000,
		PH_TOPN = 6'b010000,
		PH_BOTN = 6'b100000
	} phase_t;

	typedef struct packed {
		logic flush;
		logic start;
	} ctrl_t;

endpackage

FILE: rtl/thick_line_span_rasterizer_top.sv
// Top level of the thick line span rasterizer: front end, span queue and line walker.
//
// A load item (mode 0) names two endpoints, a brush radius and a color; a load ends any
// line in progress and starts a new one unless the radius is 0, exceeds MAX_RADIUS, or
// a coordinate lies below the radius. Each step item (mode 1) returns the next non-empty
// horizontal span of the line, clipped to screen_width and screen_height, with last_span
// set on the final one; a step with no line active returns nothing. The line walker runs
// ahead of the steps, one micro step per clock while the queue has room, and parks
// finished spans in a four-entry queue. A load retires at once, and so does a step item
// that finds a span waiting and the output register free, so one item per clock flows
// while the queue holds spans and the output register is free or popped. The walker
// sets the sustained span rate: a wide circle row is a decision step followed by four
// spans, top and bottom of its wide part and then of its narrow part, and a narrow row
// is a decision step followed by its top and bottom spans; every pen position adds its
// center row and a step to move the pen. Spans of zero length are walked like the
// others but never enter the queue. A span only enters the queue once the walker has
// found the next non-empty span or finished the line. Clipping uses the screen
// registers at the time the span is handed out.
module thick_line_span_rasterizer_top #(
	parameter int MAX_RADIUS = 63,
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// Item input.
	input  logic                              push,
	output logic                              full,
	input  logic                              mode,
	input  logic [COORD_BITS-1:0]             x_begin,
	input  logic [COORD_BITS-1:0]             y_begin,
	input  logic [COORD_BITS-1:0]             x_end_pt,
	input  logic [COORD_BITS-1:0]             y_end_pt,
	input  logic [tlsr_pkg::RAD_W-1:0]        pen_radius,
	input  logic [tlsr_pkg::COLOR_W-1:0]      pen_color,
	// Span output.
	output logic                              empty,
	input  logic                              pop,
	output logic [COORD_BITS-1:0]             span_x_first,
	output logic [COORD_BITS-1:0]             span_x_final,
	output logic [COORD_BITS-1:0]             span_row,
	output logic [tlsr_pkg::COLOR_W-1:0]      span_color,
	output logic                              last_span
);

	localparam int CB     = COORD_BITS;
	localparam int SW     = COORD_BITS + 1;
	localparam int XW     = COORD_BITS + 2;
	localparam int LW     = tlsr_pkg::LEN_W;
	localparam int RW     = tlsr_pkg::RAD_W;
	localparam int DATA_W = 2 * COORD_BITS + tlsr_pkg::LEN_W + 1;

	// Screen registers.
	logic [SW-1:0] sw_q, sh_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'(sh_q) : 32'(sw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SW'(480);
			sh_q <= SW'(800);
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				sh_q <= pwdata[SW-1:0];
			end else begin
				sw_q <= pwdata[SW-1:0];
			end
		end
	end

	// The command register holds one accepted item until it is retired in order.
	logic                         cmd_v_q, cmd_mode_q;
	logic [CB-1:0]                cmd_x1_q, cmd_y1_q, cmd_x2_q, cmd_y2_q;
	logic [RW-1:0]                cmd_r_q;
	logic [tlsr_pkg::COLOR_W-1:0] cmd_color_q, color_q;

	logic                         is_load, is_step, load_ok, out_free;
	logic                         step_pop, step_none, retire;
	logic                         gen_busy, fifo_empty, fifo_full;
	logic                         w_push, w_last;
	logic [CB-1:0]                w_x, w_y;
	logic [LW-1:0]                w_len;
	logic [DATA_W-1:0]            head;
	tlsr_pkg::ctrl_t              ctrl;

	assign is_load = cmd_v_q && (cmd_mode_q == tlsr_pkg::MODE_LOAD);
	assign is_step = cmd_v_q && (cmd_mode_q == tlsr_pkg::MODE_STEP);
	assign load_ok = (cmd_r_q != '0) && (9'(cmd_r_q) <= 9'(MAX_RADIUS))
		&& (cmd_x1_q >= CB'(cmd_r_q)) && (cmd_x2_q >= CB'(cmd_r_q))
		&& (cmd_y1_q >= CB'(cmd_r_q)) && (cmd_y2_q >= CB'(cmd_r_q));

	assign out_free  = empty || pop;
	assign step_pop  = is_step && !fifo_empty && out_free;
	// A step finds no span only once the walker has finished and the queue is drained.
	assign step_none = is_step && fifo_empty && !gen_busy;
	assign retire    = is_load || step_pop || step_none;
	assign full      = cmd_v_q && !retire;

	assign ctrl.flush = is_load;
	assign ctrl.start = is_load && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_q <= 1'b0;
		end else if (push && !full) begin
			cmd_v_q <= 1'b1;
		end else if (retire) begin
			cmd_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			cmd_mode_q  <= mode;
			cmd_x1_q    <= x_begin;
			cmd_y1_q    <= y_begin;
			cmd_x2_q    <= x_end_pt;
			cmd_y2_q    <= y_end_pt;
			cmd_r_q     <= pen_radius;
			cmd_color_q <= pen_color;
		end
		if (ctrl.start) begin
			color_q <= cmd_color_q;
		end
	end

	tlsr_walker #(
		.COORD_BITS (COORD_BITS)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.x_begin    (cmd_x1_q),
		.y_begin    (cmd_y1_q),
		.x_end_pt   (cmd_x2_q),
		.y_end_pt   (cmd_y2_q),
		.pen_radius (cmd_r_q),
		.fifo_full  (fifo_full),
		.push       (w_push),
		.push_x     (w_x),
		.push_y     (w_y),
		.push_len   (w_len),
		.push_last  (w_last),
		.busy       (gen_busy)
	);

	tlsr_fifo #(
		.DATA_W (DATA_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.push      (w_push),
		.push_data ({w_x, w_y, w_len, w_last}),
		.pop       (step_pop),
		.pop_data  (head),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	// Clipping of the span at the head of the queue.
	logic [CB-1:0] h_x, h_y, x_clip, xf_clip, y_clip;
	logic [LW-1:0] h_len;
	logic          h_last;
	logic [XW-1:0] h_end;

	assign {h_x, h_y, h_len, h_last} = head;

	always_comb begin
		h_end  = XW'(h_x) + XW'(h_len) - 1'b1;
		x_clip = h_x;
		if (h_end >= XW'(sw_q)) begin
			x_clip = CB'(sw_q - SW'(h_len) - 1'b1);
		end
		xf_clip = x_clip + CB'(h_len) - 1'b1;
		y_clip  = h_y;
		if (SW'(h_y) >= sh_q) begin
			y_clip = CB'(sh_q - 1'b1);
		end
	end

	// Output register: the span waits here while the next item is taken.
	logic out_v_q;

	assign empty = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step_pop) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_pop) begin
			span_x_first <= x_clip;
			span_x_final <= xf_clip;
			span_row     <= y_clip;
			span_color   <= color_q;
			last_span    <= h_last;
		end
	end

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		step_pop |-> !fifo_empty && out_free)
		else $error("span handed out with no span queued or no room");

	a_none_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(is_step && retire && !step_pop) |-> (!gen_busy && fifo_empty))
		else $error("step retired empty while spans may still come");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.flush && !ctrl.start) |=> (fifo_empty && !gen_busy))
		else $error("rejected load left a line running");

endmodule

FILE: rtl/tlsr_fifo.sv
// Short span queue between the line walker and the front end.
module tlsr_fifo #(
	parameter int DATA_W = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tlsr_pkg::ctrl_t   ctrl,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty,
	output logic              full
);

	localparam int PTR_W = $clog2(tlsr_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(tlsr_pkg::FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tlsr_pkg::FIFO_DEPTH - 1);

	logic [DATA_W-1:0] mem_q [tlsr_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(tlsr_pkg::FIFO_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push && !ctrl.flush) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (ctrl.flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(tlsr_pkg::FIFO_DEPTH))
		else $error("span queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("walker pushed into a full span queue");

endmodule

FILE: rtl/tlsr_walker.sv
// Line walker: DDA stepping and circle stamping, one micro step per cycle unless the span queue is full.
module tlsr_walker #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlsr_pkg::ctrl_t               ctrl,
	input  logic [COORD_BITS-1:0]         x_begin,
	input  logic [COORD_BITS-1:0]         y_begin,
	input  logic [COORD_BITS-1:0]         x_end_pt,
	input  logic [COORD_BITS-1:0]         y_end_pt,
	input  logic [tlsr_pkg::RAD_W-1:0]    pen_radius,
	input  logic                          fifo_full,
	output logic                          push,
	output logic [COORD_BITS-1:0]         push_x,
	output logic [COORD_BITS-1:0]         push_y,
	output logic [tlsr_pkg::LEN_W-1:0]    push_len,
	output logic                          push_last,
	output logic                          busy
);

	localparam int CB = COORD_BITS;
	localparam int EW = COORD_BITS + 2;
	localparam int SW = COORD_BITS + 1;
	localparam int RW = tlsr_pkg::RAD_W;
	localparam int LW = tlsr_pkg::LEN_W;
	localparam int IW = tlsr_pkg::IDX_W;
	localparam int PW = RW + tlsr_pkg::LIM_SHIFT;

	function automatic logic [CB-1:0] move_dir(input logic [CB-1:0] v, input logic [1:0] dir);
		logic [CB-1:0] res;
		res = v;
		if (dir == tlsr_pkg::DIR_POS) begin
			res = v + 1'b1;
		end else if (dir == tlsr_pkg::DIR_NEG) begin
			res = v - 1'b1;
		end
		return res;
	endfunction

	logic                        busy_q, pend_v_q;
	logic [CB-1:0]               pend_x_q, pend_y_q;
	logic [LW-1:0]               pend_len_q;
	logic [CB-1:0]               pc_q, pr_q, adx_q, ady_q, maj_q;
	logic [EW-1:0]               cerr_q, rerr_q;
	logic [1:0]                  cdir_q, rdir_q;
	logic [SW-1:0]               steps_q;
	logic [RW-1:0]               r_q;
	logic [IW-1:0]               i_q, hw_q, lim_q;
	logic [tlsr_pkg::BND_W-1:0]  bnd_q;
	tlsr_pkg::phase_t            ph_q;

	logic [CB-1:0]               pc_n, pr_n;
	logic [EW-1:0]               cerr_n, rerr_n, cerr_sum, rerr_sum;
	logic [SW-1:0]               steps_n;
	logic [IW-1:0]               i_n, hw_n;
	tlsr_pkg::phase_t            ph_n;
	logic                        done, cand_nz, adv;
	logic [CB-1:0]               cand_x, cand_y;
	logic [LW-1:0]               cand_len;
	logic [tlsr_pkg::SQ_W-1:0]   sq_sum;

	// Setup values of a new line.
	logic [CB-1:0]               s_adx, s_ady, s_maj;
	logic [1:0]                  s_cdir, s_rdir;
	logic [PW-1:0]               s_prod;
	logic [tlsr_pkg::BND_W-1:0]  s_bnd;

	always_comb begin
		s_cdir = (x_end_pt > x_begin) ? tlsr_pkg::DIR_POS :
			((x_end_pt < x_begin) ? tlsr_pkg::DIR_NEG : tlsr_pkg::DIR_NONE);
		s_rdir = (y_end_pt > y_begin) ? tlsr_pkg::DIR_POS :
			((y_end_pt < y_begin) ? tlsr_pkg::DIR_NEG : tlsr_pkg::DIR_NONE);
		s_adx  = (x_end_pt >= x_begin) ? x_end_pt - x_begin : x_begin - x_end_pt;
		s_ady  = (y_end_pt >= y_begin) ? y_end_pt - y_begin : y_begin - y_end_pt;
		s_maj  = (s_adx > s_ady) ? s_adx : s_ady;
		s_prod = PW'(pen_radius) * PW'(tlsr_pkg::LIM_MUL);
		s_bnd  = tlsr_pkg::BND_W'(pen_radius) * tlsr_pkg::BND_W'(pen_radius)
			+ tlsr_pkg::BND_W'(pen_radius >> 1);
	end

	assign adv    = busy_q && !fifo_full;
	assign sq_sum = tlsr_pkg::SQ_W'(i_q) * tlsr_pkg::SQ_W'(i_q)
		+ tlsr_pkg::SQ_W'(hw_q) * tlsr_pkg::SQ_W'(hw_q);
	assign cerr_sum = cerr_q + EW'(adx_q);
	assign rerr_sum = rerr_q + EW'(ady_q);

	always_comb begin
		pc_n     = pc_q;
		pr_n     = pr_q;
		cerr_n   = cerr_q;
		rerr_n   = rerr_q;
		steps_n  = steps_q;
		i_n      = i_q;
		hw_n     = hw_q;
		ph_n     = ph_q;
		done     = 1'b0;
		cand_x   = pc_q;
		cand_y   = pr_q;
		cand_len = '0;
		unique case (ph_q)
			tlsr_pkg::PH_ROW0: begin
				cand_x   = pc_q - CB'(r_q);
				cand_y   = pr_q;
				cand_len = LW'({r_q, 1'b0});
				i_n      = IW'(1);
				ph_n     = tlsr_pkg::PH_SCAN;
			end
			tlsr_pkg::PH_TOPW: begin
				cand_x   = pc_q - CB'(i_q) + 1'b1;
				cand_y   = pr_q + CB'(hw_q);
				cand_len = LW'({i_q - 1'b1, 1'b0});
				ph_n     = tlsr_pkg::PH_BOTW;
			end
			tlsr_pkg::PH_BOTW: begin
				cand_x   = pc_q - CB'(i_q) + 1'b1;
				cand_y   = pr_q - CB'(hw_q);
				cand_len = LW'({i_q - 1'b1, 1'b0});
				if (hw_q != '0) begin
					hw_n = hw_q - 1'b1;
				end
				ph_n     = tlsr_pkg::PH_TOPN;
			end
			tlsr_pkg::PH_TOPN: begin
				cand_x   = pc_q - CB'(hw_q);
				cand_y   = pr_q + CB'(i_q);
				cand_len = LW'({hw_q, 1'b0});
				ph_n     = tlsr_pkg::PH_BOTN;
			end
			tlsr_pkg::PH_BOTN: begin
				cand_x   = pc_q - CB'(hw_q);
				cand_y   = pr_q - CB'(i_q);
				cand_len = LW'({hw_q, 1'b0});
				i_n      = i_q + 1'b1;
				ph_n     = tlsr_pkg::PH_SCAN;
			end
			default: begin
				ph_n = tlsr_pkg::PH_SCAN;
				if (i_q > lim_q) begin
					// Circle done: advance the pen one DDA step.
					cerr_n = cerr_sum;
					rerr_n = rerr_sum;
					if (cerr_sum > EW'(maj_q)) begin
						cerr_n = cerr_sum - EW'(maj_q);
						pc_n   = move_dir(pc_q, cdir_q);
					end
					if (rerr_sum > EW'(maj_q)) begin
						rerr_n = rerr_sum - EW'(maj_q);
						pr_n   = move_dir(pr_q, rdir_q);
					end
					steps_n = (steps_q != '0) ? steps_q - 1'b1 : steps_q;
					if (steps_n == '0) begin
						done = 1'b1;
					end else begin
						ph_n = tlsr_pkg::PH_ROW0;
						hw_n = IW'(r_q);
					end
				end else if (sq_sum > tlsr_pkg::SQ_W'(bnd_q)) begin
					if (hw_q > lim_q) begin
						ph_n = tlsr_pkg::PH_TOPW;
					end else begin
						if (hw_q != '0) begin
							hw_n = hw_q - 1'b1;
						end
						ph_n = tlsr_pkg::PH_TOPN;
					end
				end else begin
					ph_n = tlsr_pkg::PH_TOPN;
				end
			end
		endcase
	end

	assign cand_nz   = (cand_len != '0);
	assign push      = adv && pend_v_q && (done || cand_nz);
	assign push_x    = pend_x_q;
	assign push_y    = pend_y_q;
	assign push_len  = pend_len_q;
	assign push_last = done;
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pend_v_q <= 1'b0;
			ph_q     <= tlsr_pkg::PH_ROW0;
		end else if (ctrl.start) begin
			busy_q   <= 1'b1;
			pend_v_q <= 1'b0;
			ph_q     <= tlsr_pkg::PH_ROW0;
		end else if (ctrl.flush) begin
			busy_q   <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (adv) begin
			ph_q <= ph_n;
			if (done) begin
				busy_q   <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (cand_nz) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			pc_q    <= x_begin;
			pr_q    <= y_begin;
			cerr_q  <= '0;
			rerr_q  <= '0;
			adx_q   <= s_adx;
			ady_q   <= s_ady;
			maj_q   <= s_maj;
			cdir_q  <= s_cdir;
			rdir_q  <= s_rdir;
			steps_q <= SW'(s_maj) + SW'(2);
			r_q     <= pen_radius;
			i_q     <= '0;
			hw_q    <= IW'(pen_radius);
			lim_q   <= IW'(s_prod[PW-1:tlsr_pkg::LIM_SHIFT]) + 1'b1;
			bnd_q   <= s_bnd;
		end else if (adv) begin
			pc_q    <= pc_n;
			pr_q    <= pr_n;
			cerr_q  <= cerr_n;
			rerr_q  <= rerr_n;
			steps_q <= steps_n;
			i_q     <= i_n;
			hw_q    <= hw_n;
			if (cand_nz) begin
				pend_x_q   <= cand_x;
				pend_y_q   <= cand_y;
				pend_len_q <= cand_len;
			end
		end
	end

endmodule

FILE: tb/tb_thick_line_span_rasterizer_top.sv
// Self-checking testbench for the thick line span rasterizer top level.
`timescale 1ns / 1ps

module tb_thick_line_span_rasterizer_top;

	localparam int CW         = 12;
	localparam int MAX_RAD    = 63;
	localparam int CYCLE_CAP  = 1500000;
	localparam int DRAIN_WAIT = 60;
	localparam int FIFO_WAIT  = 40;

	// Expected span as it should appear on the result ports.
	typedef struct {
		logic [CW-1:0]                x_first;
		logic [CW-1:0]                x_final;
		logic [CW-1:0]                row;
		logic [tlsr_pkg::COLOR_W-1:0] color;
		logic                         last;
	} span_t;

	// Walker state of the line being drawn, kept in 32-bit unsigned terms.
	typedef struct {
		int unsigned busy, pc, pr, cerr, rerr, adx, ady, major, cdir, rdir, steps;
		int unsigned rad, color, ri, hw, lim, bound, ph;
	} walk_t;

	// Predicts the span stream and checks every transfer on the result side.
	class span_scoreboard;
		walk_t       pen;
		int unsigned scr_w = 480;
		int unsigned scr_h = 800;
		span_t       spans_due[$];
		int          mismatches = 0;

		function int unsigned step_dir(int unsigned v, int unsigned d);
			if (d == tlsr_pkg::DIR_POS) return (v + 1) & 12'hFFF;
			if (d == tlsr_pkg::DIR_NEG) return (v + 12'hFFF) & 12'hFFF;
			return v & 12'hFFF;
		endfunction

		// One walker step: 0 = nothing, 1 = span candidate, 2 = line done.
		function int walk_once(ref walk_t s, ref int unsigned x0, ref int unsigned y0,
				ref int unsigned len);
			int unsigned r, x, i;
			r = s.rad;
			x = s.hw;
			i = s.ri;
			case (s.ph)
				0: begin
					x0 = (s.pc - r) & 12'hFFF; y0 = s.pr; len = 2 * r;
					s.ri = 1; s.ph = 1;
					return 1;
				end
				2: begin
					x0 = (s.pc - i + 1) & 12'hFFF; y0 = (s.pr + x) & 12'hFFF;
					len = 2 * (i - 1); s.ph = 3;
					return 1;
				end
				3: begin
					x0 = (s.pc - i + 1) & 12'hFFF; y0 = (s.pr - x) & 12'hFFF;
					len = 2 * (i - 1);
					if (x > 0) s.hw = x - 1;
					s.ph = 4;
					return 1;
				end
				4: begin
					x0 = (s.pc - x) & 12'hFFF; y0 = (s.pr + i) & 12'hFFF; len = 2 * x;
					s.ph = 5;
					return 1;
				end
				5: begin
					x0 = (s.pc - x) & 12'hFFF; y0 = (s.pr - i) & 12'hFFF; len = 2 * x;
					s.ri = i + 1; s.ph = 1;
					return 1;
				end
				default: begin
					s.ph = 1;
					if (i > s.lim) begin
						// The circle is done: advance the pen one position.
						s.cerr += s.adx;
						s.rerr += s.ady;
						if (s.cerr > s.major) begin
							s.cerr -= s.major;
							s.pc = step_dir(s.pc, s.cdir);
						end
						if (s.rerr > s.major) begin
							s.rerr -= s.major;
							s.pr = step_dir(s.pr, s.rdir);
						end
						if (s.steps > 0) s.steps--;
						if (s.steps == 0) begin
							s.busy = 0;
							return 2;
						end
						s.ph = 0;
						s.hw = r;
						return 0;
					end
					if (i * i + x * x > s.bound) begin
						if (x > s.lim) s.ph = 2;
						else begin
							if (x > 0) s.hw = x - 1;
							s.ph = 4;
						end
					end else s.ph = 4;
					return 0;
				end
			endcase
		endfunction

		// Runs the walker to the next non-empty span.
		function bit next_span(ref walk_t s, ref int unsigned x0, ref int unsigned y0,
				ref int unsigned len);
			int k;
			while (s.busy) begin
				k = walk_once(s, x0, y0, len);
				if (k == 2) return 0;
				if (k == 1 && len != 0) return 1;
			end
			return 0;
		endfunction

		function void note_item(logic md, int unsigned x1, int unsigned y1, int unsigned x2,
				int unsigned y2, int unsigned r, int unsigned c);
			walk_t       look;
			int unsigned x0, y0, len, px, py, pl;
			span_t       sp;
			if (md == tlsr_pkg::MODE_LOAD) begin
				pen.busy = 0;
				if (r == 0 || r > MAX_RAD || x1 < r || x2 < r || y1 < r || y2 < r) return;
				pen.cdir  = (x2 > x1) ? tlsr_pkg::DIR_POS :
					((x2 < x1) ? tlsr_pkg::DIR_NEG : tlsr_pkg::DIR_NONE);
				pen.rdir  = (y2 > y1) ? tlsr_pkg::DIR_POS :
					((y2 < y1) ? tlsr_pkg::DIR_NEG : tlsr_pkg::DIR_NONE);
				pen.adx   = (x2 >= x1) ? x2 - x1 : x1 - x2;
				pen.ady   = (y2 >= y1) ? y2 - y1 : y1 - y2;
				pen.major = (pen.adx > pen.ady) ? pen.adx : pen.ady;
				pen.steps = pen.major + 2;
				pen.pc    = x1;
				pen.pr    = y1;
				pen.cerr  = 0;
				pen.rerr  = 0;
				pen.rad   = r;
				pen.color = c;
				pen.ri    = 0;
				pen.hw    = r;
				pen.lim   = (r * 707) / 1000 + 1;
				pen.bound = r * r + r / 2;
				pen.ph    = 0;
				pen.busy  = 1;
				return;
			end
			if (!next_span(pen, x0, y0, len)) return;
			// Peek ahead on a copy to learn whether this is the final span.
			look = pen;
			if (next_span(look, px, py, pl)) sp.last = 1'b0;
			else begin
				sp.last  = 1'b1;
				pen.busy = 0;
			end
			if (x0 + len - 1 >= scr_w) x0 = (scr_w - len - 1) & 12'hFFF;
			if (y0 >= scr_h) y0 = (scr_h - 1) & 12'hFFF;
			sp.x_first = x0[CW-1:0];
			sp.x_final = CW'((x0 + len - 1) & 12'hFFF);
			sp.row     = y0[CW-1:0];
			sp.color   = pen.color[tlsr_pkg::COLOR_W-1:0];
			spans_due.push_back(sp);
		endfunction

		function void check_span(span_t got);
			span_t want;
			if (spans_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: span transfer with none expected: x %0d..%0d row %0d",
						$realtime, got.x_first, got.x_final, got.row);
				return;
			end
			want = spans_due.pop_front();
			if (got.x_first !== want.x_first || got.x_final !== want.x_final ||
					got.row !== want.row || got.color !== want.color ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: want %0d..%0d r%0d c%h l%0d, got %0d..%0d r%0d c%h l%0d",
						$realtime, want.x_first, want.x_final, want.row, want.color,
						want.last, got.x_first, got.x_final, got.row, got.color, got.last);
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         psel, penable, pwrite;
	logic [2:0]                   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         push, full, mode;
	logic [CW-1:0]                x_begin, y_begin, x_end_pt, y_end_pt;
	logic [tlsr_pkg::RAD_W-1:0]   pen_radius;
	logic [tlsr_pkg::COLOR_W-1:0] pen_color;
	logic                         empty, pop;
	logic [CW-1:0]                span_x_first, span_x_final, span_row;
	logic [tlsr_pkg::COLOR_W-1:0] span_color;
	logic                         last_span;

	span_scoreboard sb;
	bit             quiet;      // no idling on either side in the final stretch
	int             long_hold;  // receiver hold-off request, counted down by the receiver
	int             cycles;
	int             sent;

	thick_line_span_rasterizer_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.x_begin      (x_begin),
		.y_begin      (y_begin),
		.x_end_pt     (x_end_pt),
		.y_end_pt     (y_end_pt),
		.pen_radius   (pen_radius),
		.pen_color    (pen_color),
		.empty        (empty),
		.pop          (pop),
		.span_x_first (span_x_first),
		.span_x_final (span_x_final),
		.span_row     (span_row),
		.span_color   (span_color),
		.last_span    (last_span)
	);

	// 8 ns clock.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Every input starts at a known value; reset is applied once, at the start.
	initial begin
		sb         = new();
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		push       = 1'b0;
		mode       = tlsr_pkg::MODE_STEP;
		x_begin    = '0;
		y_begin    = '0;
		x_end_pt   = '0;
		y_end_pt   = '0;
		pen_radius = '0;
		pen_color  = '0;
		pop        = 1'b0;
		quiet      = 1'b0;
		long_hold  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: a run that never drains is a failure.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stalls in bursts, plus the long hold-off that the stimulus asks for,
	// so the span queue fills and the input side backs up.
	initial begin : receiver
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				pop <= 1'b0;
				long_hold--;
			end else if (quiet) pop <= 1'b1;
			else if (burst > 0) begin
				pop <= 1'b0;
				burst--;
			end else if ($urandom_range(0, 5) == 0) begin
				pop   <= 1'b0;
				burst = $urandom_range(0, 3);
			end else pop <= 1'b1;
		end
	end

	// Result monitor: a span transfer happens at an edge with pop high and empty low.
	always @(posedge clk) begin
		span_t got;
		if (arst_n && pop && !empty) begin
			got.x_first = span_x_first;
			got.x_final = span_x_final;
			got.row     = span_row;
			got.color   = span_color;
			got.last    = last_span;
			sb.check_span(got);
		end
	end

	// Offers one item and waits for its transfer; the prediction is updated right at
	// the accepting edge. Afterwards the sender may go quiet for a short burst.
	task automatic offer(logic md, int unsigned x1, int unsigned y1, int unsigned x2,
			int unsigned y2, int unsigned r, int unsigned c);
		push       <= 1'b1;
		mode       <= md;
		x_begin    <= CW'(x1);
		y_begin    <= CW'(y1);
		x_end_pt   <= CW'(x2);
		y_end_pt   <= CW'(y2);
		pen_radius <= tlsr_pkg::RAD_W'(r);
		pen_color  <= tlsr_pkg::COLOR_W'(c);
		do @(posedge clk); while (full);
		sb.note_item(md, x1 & 12'hFFF, y1 & 12'hFFF, x2 & 12'hFFF, y2 & 12'hFFF,
			r & 6'h3F, c & 16'hFFFF);
		sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// A step item carries random payload that the block must ignore.
	task automatic step_span();
		offer(tlsr_pkg::MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endtask

	// Steps until the predicted line has ended, with a cap for big brushes.
	task automatic finish_line(int cap);
		int n;
		n = 0;
		while (sb.pen.busy && n < cap) begin
			step_span();
			n++;
		end
	endtask

	// Waits until every expected span has arrived and the walker has settled, then
	// writes one register through a setup and an access cycle.
	task automatic write_reg(int idx, int unsigned val);
		push <= 1'b0;
		while (sb.spans_due.size() != 0) @(posedge clk);
		repeat (FIFO_WAIT) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * idx);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == 0) sb.scr_w = val & 13'h1FFF;
		else sb.scr_h = val & 13'h1FFF;
	endtask

	// A coordinate near a point of interest, never below the radius.
	function automatic int unsigned pick_coord(int unsigned r, int unsigned edge_at);
		int unsigned v;
		case ($urandom_range(0, 3))
			0: v = r + $urandom_range(0, 8);
			1: v = (edge_at > 8 ? edge_at - 8 : 0) + $urandom_range(0, 16);
			2: v = $urandom_range(4080, 4095);
			default: v = $urandom_range(0, 4095);
		endcase
		if (v < r) v = r;
		return (v > 4095) ? 4095 : v;
	endfunction

	function automatic int unsigned nudge(int unsigned v, int unsigned r, int span);
		int w;
		w = int'(v) + $urandom_range(0, 2 * span) - span;
		if (w < int'(r)) w = r;
		if (w > 4095) w = 4095;
		return w;
	endfunction

	// One random sequence: mostly well-formed lines walked part way or to the end,
	// with rejected loads and stray steps mixed in.
	task automatic random_sequence();
		int unsigned r, x1, y1, x2, y2;
		int          kind, reach;
		kind = $urandom_range(0, 99);
		if (kind < 8) r = $urandom_range(9, 63);
		else r = $urandom_range(1, 8);
		reach = ($urandom_range(0, 9) == 0) ? 60 : 5;
		x1 = pick_coord(r, sb.scr_w);
		y1 = pick_coord(r, sb.scr_h);
		x2 = nudge(x1, r, reach);
		y2 = nudge(y1, r, reach);
		if (kind < 70) begin
			offer(tlsr_pkg::MODE_LOAD, x1, y1, x2, y2, r, $urandom);
			if (r <= 4 && reach == 5 && $urandom_range(0, 1) == 0) finish_line(400);
			else repeat ($urandom_range(1, 40)) step_span();
		end else if (kind < 85) begin
			// Rejected load: zero radius or a coordinate below the radius.
			if ($urandom_range(0, 1) == 0)
				offer(tlsr_pkg::MODE_LOAD, x1, y1, x2, y2, 0, $urandom);
			else begin
				r = $urandom_range(1, 63);
				case ($urandom_range(0, 3))
					0: x1 = $urandom_range(0, r - 1);
					1: y1 = $urandom_range(0, r - 1);
					2: x2 = $urandom_range(0, r - 1);
					default: y2 = $urandom_range(0, r - 1);
				endcase
				offer(tlsr_pkg::MODE_LOAD, x1, y1, x2, y2, r, $urandom);
			end
			repeat ($urandom_range(0, 3)) step_span();
		end else if (kind < 93) begin
			// Fully random load, followed by a few steps.
			offer(tlsr_pkg::MODE_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
			repeat ($urandom_range(0, 10)) step_span();
		end else repeat ($urandom_range(1, 4)) step_span();
	endtask

	// Screen settings per phase: reset values, smallest, largest, then two more.
	int unsigned widths[5]  = '{480, 1, 4096, 0, 100};
	int unsigned heights[5] = '{800, 1, 4096, 0, 3000};

	initial begin : stimulus
		int target;
		sent = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed: idle step, extreme brushes and coordinates, rejects, load while busy.
		step_span();
		offer(tlsr_pkg::MODE_LOAD, 63, 63, 63, 63, 63, 16'hFFFF);
		repeat (4) step_span();
		offer(tlsr_pkg::MODE_LOAD, 4095, 4095, 4095 - 3, 4095 - 2, 63, 16'h0000);
		repeat (3) step_span();
		offer(tlsr_pkg::MODE_LOAD, 10, 10, 20, 20, 0, 16'h1234);
		step_span();
		offer(tlsr_pkg::MODE_LOAD, 5, 10, 20, 20, 6, 16'hA5A5);
		step_span();
		offer(tlsr_pkg::MODE_LOAD, 1, 1, 1, 1, 1, 16'h5A5A);
		finish_line(20);
		step_span();
		offer(tlsr_pkg::MODE_LOAD, 479, 799, 476, 803, 2, 16'hF00F);
		finish_line(200);
		offer(tlsr_pkg::MODE_LOAD, 2, 4095, 5, 4094, 2, 16'h0FF0);
		finish_line(200);

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				write_reg(0, (widths[p] == 0) ? $urandom_range(1, 4096) : widths[p]);
				write_reg(1, (heights[p] == 0) ? $urandom_range(1, 4096) : heights[p]);
			end
			target = sent + 360;
			if (p == 2) begin
				// Hold the receiver off while items keep coming so the block fills up.
				offer(tlsr_pkg::MODE_LOAD, 200, 200, 230, 210, 20, $urandom);
				long_hold = 300;
				repeat (30) step_span();
			end
			while (sent < target) begin
				if (p == 4 && target - sent < 150) quiet = 1'b1;
				random_sequence();
			end
		end

		push <= 1'b0;
		while (sb.spans_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
